@@ hdl/logical_rect_pixel_projection_macros.svh @@
// assertion macros shared by the projection block
`ifndef LOGICAL_RECT_PIXEL_PROJECTION_MACROS_SVH
`define LOGICAL_RECT_PIXEL_PROJECTION_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define LRPP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LRPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LRPP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define LRPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ hdl/lrpp_pkg.sv @@
`default_nettype none
package lrpp_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_SCALE_X  = 3'd0;
  localparam logic [2:0] CFG_SCALE_Y  = 3'd1;
  localparam logic [2:0] CFG_VIEW_L   = 3'd2;
  localparam logic [2:0] CFG_VIEW_T   = 3'd3;
  localparam logic [2:0] CFG_VIEW_W   = 3'd4;
  localparam logic [2:0] CFG_VIEW_H   = 3'd5;

  // reset values
  localparam logic [23:0] SCALE_ONE   = 24'h010000;

  // pixel range limit
  localparam logic [15:0] PIX_MAX     = 16'hFFFF;

  // rounding biases on the Q.24 accumulator
  localparam logic [59:0] Q24_HALF    = 60'h0000000_0080_0000;
  localparam logic [59:0] Q24_HALF_M1 = 60'h0000000_007F_FFFF;
  localparam logic [59:0] Q24_ONE_M1  = 60'h0000000_00FF_FFFF;

  // length of the valid pipeline from an accepted beat to its result strobe
  localparam int LAT = 6;

  // projected span of one axis, both ends clamped to the viewport
  typedef struct packed {
    logic [15:0] lo;
    logic [15:0] hi;
  } axis_span_t;

endpackage
`default_nettype wire

@@ hdl/logical_rect_pixel_projection.sv @@
// Projects one paint rectangle and its clip rectangle per beat from logical
// Q23.8 units onto the pixel viewport. A beat is taken on every cycle with
// start high (busy is never raised), and its result is strobed on out_valid
// once four axis units and a radius unit have run a five-stage
// multiply/round/clamp pipeline and one more stage has formed the
// clip flags, radius cap and output registers. The receiver cannot stall,
// so results must be taken in the cycle they are strobed. Write the cfg_
// registers only while no beat is in flight.
`default_nettype none
`include "logical_rect_pixel_projection_macros.svh"
module logical_rect_pixel_projection (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration port
  input  wire logic               cfg_we,
  input  wire logic        [2:0]  cfg_addr,
  input  wire logic        [23:0] cfg_wdata,
  // input beat
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_rect_x,
  input  wire logic signed [31:0] in_rect_y,
  input  wire logic        [30:0] in_rect_w,
  input  wire logic        [30:0] in_rect_h,
  input  wire logic               in_use_shared_end,
  input  wire logic signed [31:0] in_end_x,
  input  wire logic signed [31:0] in_end_y,
  input  wire logic signed [31:0] in_clip_x,
  input  wire logic signed [31:0] in_clip_y,
  input  wire logic        [30:0] in_clip_w,
  input  wire logic        [30:0] in_clip_h,
  input  wire logic        [23:0] in_corner_radius,
  // result beat
  output logic                    out_valid,
  output logic             [15:0] out_pix_x,
  output logic             [15:0] out_pix_y,
  output logic             [15:0] out_pix_w,
  output logic             [15:0] out_pix_h,
  output logic             [15:0] out_clip_px_x,
  output logic             [15:0] out_clip_px_y,
  output logic             [15:0] out_clip_px_w,
  output logic             [15:0] out_clip_px_h,
  output logic                    out_clip_needed,
  output logic                    out_clip_elided,
  output logic             [22:0] out_pix_radius
);

  // configuration registers
  logic [23:0] scale_x_r;
  logic [23:0] scale_y_r;
  logic [14:0] view_left_r;
  logic [14:0] view_top_r;
  logic [15:0] view_width_r;
  logic [15:0] view_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r     <= lrpp_pkg::SCALE_ONE;
      scale_y_r     <= lrpp_pkg::SCALE_ONE;
      view_left_r   <= '0;
      view_top_r    <= '0;
      view_width_r  <= '0;
      view_height_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lrpp_pkg::CFG_SCALE_X: scale_x_r     <= cfg_wdata;
        lrpp_pkg::CFG_SCALE_Y: scale_y_r     <= cfg_wdata;
        lrpp_pkg::CFG_VIEW_L:  view_left_r   <= cfg_wdata[14:0];
        lrpp_pkg::CFG_VIEW_T:  view_top_r    <= cfg_wdata[14:0];
        lrpp_pkg::CFG_VIEW_W:  view_width_r  <= cfg_wdata[15:0];
        lrpp_pkg::CFG_VIEW_H:  view_height_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // viewport far edges, saturated at the pixel range
  logic [16:0] ve_x_sum;
  logic [16:0] ve_y_sum;
  logic [15:0] ve_x;
  logic [15:0] ve_y;

  assign ve_x_sum = {2'b00, view_left_r} + {1'b0, view_width_r};
  assign ve_y_sum = {2'b00, view_top_r} + {1'b0, view_height_r};
  assign ve_x     = ve_x_sum[16] ? lrpp_pkg::PIX_MAX : ve_x_sum[15:0];
  assign ve_y     = ve_y_sum[16] ? lrpp_pkg::PIX_MAX : ve_y_sum[15:0];

  // beat acceptance and valid pipeline
  logic                    accept;
  logic [lrpp_pkg::LAT-1:0] vld_r;
  logic [lrpp_pkg::LAT-1:0] vld_nxt;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign vld_nxt = {vld_r[lrpp_pkg::LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // axis units
  lrpp_pkg::axis_span_t bx;
  lrpp_pkg::axis_span_t by;
  lrpp_pkg::axis_span_t cx;
  lrpp_pkg::axis_span_t cy;

  lrpp_axis u_bound_x (
    .clk    (clk),
    .origin (in_rect_x),
    .extent (in_rect_w),
    .shared (in_use_shared_end),
    .endp   (in_end_x),
    .scale  (scale_x_r),
    .vstart (view_left_r),
    .vend   (ve_x),
    .span   (bx)
  );

  lrpp_axis u_bound_y (
    .clk    (clk),
    .origin (in_rect_y),
    .extent (in_rect_h),
    .shared (in_use_shared_end),
    .endp   (in_end_y),
    .scale  (scale_y_r),
    .vstart (view_top_r),
    .vend   (ve_y),
    .span   (by)
  );

  lrpp_axis u_clip_x (
    .clk    (clk),
    .origin (in_clip_x),
    .extent (in_clip_w),
    .shared (1'b0),
    .endp   (in_clip_x),
    .scale  (scale_x_r),
    .vstart (view_left_r),
    .vend   (ve_x),
    .span   (cx)
  );

  lrpp_axis u_clip_y (
    .clk    (clk),
    .origin (in_clip_y),
    .extent (in_clip_h),
    .shared (1'b0),
    .endp   (in_clip_y),
    .scale  (scale_y_r),
    .vstart (view_top_r),
    .vend   (ve_y),
    .span   (cy)
  );

  // radius unit
  logic [32:0] pr;

  lrpp_radius u_radius (
    .clk     (clk),
    .radius  (in_corner_radius),
    .scale_x (scale_x_r),
    .scale_y (scale_y_r),
    .pr      (pr)
  );

  // final stage: extents, clip flags, radius cap
  logic [15:0] bw;
  logic [15:0] bh;
  logic [15:0] side;
  logic [22:0] cap;
  logic [22:0] pr_cap;
  logic        empty;
  logic        cov;

  assign bw     = bx.hi - bx.lo;
  assign bh     = by.hi - by.lo;
  assign empty  = (bw == '0) || (bh == '0);
  assign cov    = (cx.lo <= bx.lo) && (cy.lo <= by.lo) &&
                  (cx.hi >= bx.hi) && (cy.hi >= by.hi);
  assign side   = (bw < bh) ? bw : bh;
  assign cap    = {side, 7'd0};
  assign pr_cap = (pr > {10'd0, cap}) ? cap : pr[22:0];

  logic [15:0] pix_x_r;
  logic [15:0] pix_y_r;
  logic [15:0] pix_w_r;
  logic [15:0] pix_h_r;
  logic [15:0] clip_px_x_r;
  logic [15:0] clip_px_y_r;
  logic [15:0] clip_px_w_r;
  logic [15:0] clip_px_h_r;
  logic        clip_needed_r;
  logic        clip_elided_r;
  logic [22:0] pix_radius_r;

  always_ff @(posedge clk) begin
    pix_x_r       <= bx.lo;
    pix_y_r       <= by.lo;
    pix_w_r       <= bw;
    pix_h_r       <= bh;
    clip_px_x_r   <= cx.lo;
    clip_px_y_r   <= cy.lo;
    clip_px_w_r   <= cx.hi - cx.lo;
    clip_px_h_r   <= cy.hi - cy.lo;
    clip_needed_r <= !empty && !cov;
    clip_elided_r <= !empty && cov;
    pix_radius_r  <= empty ? '0 : pr_cap;
  end

  assign out_valid       = vld_r[lrpp_pkg::LAT-1];
  assign out_pix_x       = pix_x_r;
  assign out_pix_y       = pix_y_r;
  assign out_pix_w       = pix_w_r;
  assign out_pix_h       = pix_h_r;
  assign out_clip_px_x   = clip_px_x_r;
  assign out_clip_px_y   = clip_px_y_r;
  assign out_clip_px_w   = clip_px_w_r;
  assign out_clip_px_h   = clip_px_h_r;
  assign out_clip_needed = clip_needed_r;
  assign out_clip_elided = clip_elided_r;
  assign out_pix_radius  = pix_radius_r;

  // checks
  `LRPP_ASSERT_IMPL(a_flags_excl, clk, rst_n, out_valid,
    !(out_clip_needed && out_clip_elided), "clip flags both set")
  `LRPP_ASSERT_IMPL(a_empty_quiet, clk, rst_n,
    out_valid && (out_pix_w == '0 || out_pix_h == '0),
    !out_clip_needed && !out_clip_elided && out_pix_radius == '0,
    "empty bounds carry flags or radius")
  `LRPP_ASSERT_IMPL(a_radius_cap, clk, rst_n, out_valid,
    out_pix_radius <= {out_pix_w, 7'd0} && out_pix_radius <= {out_pix_h, 7'd0},
    "radius above half the smaller side")
  `LRPP_ASSERT_IMPL(a_latency, clk, rst_n, out_valid,
    $past(start, lrpp_pkg::LAT), "result without a beat taken six cycles before")
  `LRPP_ASSERT_NEXT(a_no_phantom, clk, rst_n, !vld_r[lrpp_pkg::LAT-2], !out_valid,
    "result strobe without a valid tail stage")

endmodule
`default_nettype wire

@@ hdl/lrpp_axis.sv @@
`default_nettype none
module lrpp_axis (
  input  wire logic               clk,
  input  wire logic signed [31:0] origin,
  input  wire logic        [30:0] extent,
  input  wire logic               shared,
  input  wire logic signed [31:0] endp,
  input  wire logic        [23:0] scale,
  input  wire logic        [14:0] vstart,
  input  wire logic        [15:0] vend,
  output lrpp_pkg::axis_span_t    span
);

  // stage a: logical end point
  logic signed [31:0] org_a_r;
  logic signed [32:0] lend_a_r;
  logic signed [32:0] lend_nxt;
  logic               zero_a_r;
  logic               shared_a_r;

  always_comb begin
    if (shared) begin
      lend_nxt = {endp[31], endp};
    end else begin
      lend_nxt = $signed({origin[31], origin}) + $signed({2'b00, extent});
    end
  end

  always_ff @(posedge clk) begin
    org_a_r    <= origin;
    lend_a_r   <= lend_nxt;
    zero_a_r   <= (extent == '0);
    shared_a_r <= shared;
  end

  // stage b: scale both ends into Q.24
  logic signed [24:0] sc;
  logic signed [32:0] org_ext;
  logic signed [57:0] prod_s_b_r;
  logic signed [57:0] prod_e_b_r;
  logic               zero_b_r;
  logic               shared_b_r;

  assign sc      = $signed({1'b0, scale});
  assign org_ext = {org_a_r[31], org_a_r};

  always_ff @(posedge clk) begin
    prod_s_b_r <= org_ext * sc;
    prod_e_b_r <= lend_a_r * sc;
    zero_b_r   <= zero_a_r;
    shared_b_r <= shared_a_r;
  end

  // stage c: add the viewport origin
  logic [59:0] base;
  logic [59:0] v_s_c_r;
  logic [59:0] v_e_c_r;
  logic        zero_c_r;
  logic        shared_c_r;

  assign base = {21'd0, vstart, 24'd0};

  always_ff @(posedge clk) begin
    v_s_c_r    <= base + {{2{prod_s_b_r[57]}}, prod_s_b_r};
    v_e_c_r    <= base + {{2{prod_e_b_r[57]}}, prod_e_b_r};
    zero_c_r   <= zero_b_r;
    shared_c_r <= shared_b_r;
  end

  // stage d: floor / ceiling / half away from zero
  logic [59:0] bias_s;
  logic [59:0] bias_e;
  logic [59:0] sum_s;
  logic [59:0] sum_e;
  logic signed [35:0] s_d_r;
  logic signed [35:0] e_d_r;

  always_comb begin
    if (shared_c_r) begin
      bias_s = v_s_c_r[59] ? lrpp_pkg::Q24_HALF_M1 : lrpp_pkg::Q24_HALF;
      bias_e = v_e_c_r[59] ? lrpp_pkg::Q24_HALF_M1 : lrpp_pkg::Q24_HALF;
    end else begin
      bias_s = '0;
      bias_e = lrpp_pkg::Q24_ONE_M1;
    end
    sum_s = v_s_c_r + bias_s;
    sum_e = v_e_c_r + bias_e;
  end

  always_ff @(posedge clk) begin
    s_d_r <= $signed(sum_s[59:24]);
    e_d_r <= zero_c_r ? $signed(sum_s[59:24]) : $signed(sum_e[59:24]);
  end

  // stage e: clamp to the viewport, end never below start
  function automatic logic [15:0] clamp_pix(input logic signed [35:0] v,
                                            input logic [15:0] lo,
                                            input logic [15:0] hi);
    logic [15:0] r;
    if (v < $signed({20'd0, lo})) begin
      r = lo;
    end else if (v > $signed({20'd0, hi})) begin
      r = hi;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic [15:0] vs16;
  logic [15:0] s_cl;
  logic [15:0] e_cl;
  lrpp_pkg::axis_span_t span_r;

  assign vs16 = {1'b0, vstart};
  assign s_cl = clamp_pix(s_d_r, vs16, vend);
  assign e_cl = clamp_pix(e_d_r, vs16, vend);

  always_ff @(posedge clk) begin
    span_r.lo <= s_cl;
    span_r.hi <= (e_cl < s_cl) ? s_cl : e_cl;
  end

  assign span = span_r;

endmodule
`default_nettype wire

@@ hdl/lrpp_radius.sv @@
`default_nettype none
module lrpp_radius (
  input  wire logic        clk,
  input  wire logic [23:0] radius,
  input  wire logic [23:0] scale_x,
  input  wire logic [23:0] scale_y,
  output logic      [32:0] pr
);

  // stage a: smaller scale
  logic [23:0] rad_a_r;
  logic [23:0] smin_a_r;

  always_ff @(posedge clk) begin
    rad_a_r  <= radius;
    smin_a_r <= (scale_x < scale_y) ? scale_x : scale_y;
  end

  // stage b: radius product in Q.24
  logic [47:0] prod_b_r;

  always_ff @(posedge clk) begin
    prod_b_r <= rad_a_r * smin_a_r;
  end

  // stage c: round to Q25.8
  logic [48:0] rsum;
  logic [32:0] pr_c_r;

  assign rsum = {1'b0, prod_b_r} + 49'h0_0000_0000_8000;

  always_ff @(posedge clk) begin
    pr_c_r <= rsum[48:16];
  end

  // stages d and e: line up with the axis units
  logic [32:0] pr_d_r;
  logic [32:0] pr_e_r;

  always_ff @(posedge clk) begin
    pr_d_r <= pr_c_r;
    pr_e_r <= pr_d_r;
  end

  assign pr = pr_e_r;

endmodule
`default_nettype wire
